// ===== rtl/core/hfar_pkg.sv =====
// shared types, constants and helpers for the hopfield recall engine
// used by hfar_field, hfar_seq and the top level under rtl/core; no dependencies of its own
`default_nettype none

package hfar_pkg;

    // network size and weight precision
    localparam int N_SITES     = 64;
    localparam int WEIGHT_BITS = 16;

    // fixed field widths of the request and result transactions
    localparam int IDX_BITS  = 6;
    localparam int WIN_BITS  = 16;
    localparam int TYPE_BITS = 2;

    // derived storage widths
    localparam int SITE_BITS  = (N_SITES > 1) ? $clog2(N_SITES) : 1;
    localparam int WDEPTH     = N_SITES * N_SITES;
    localparam int WADDR_BITS = $clog2(WDEPTH);
    localparam int ACC_BITS   = WEIGHT_BITS + SITE_BITS + 1;

    // request kinds
    localparam logic [TYPE_BITS-1:0] REQ_WR_WEIGHT = 2'd0;
    localparam logic [TYPE_BITS-1:0] REQ_WR_SPIN   = 2'd1;
    localparam logic [TYPE_BITS-1:0] REQ_STEP      = 2'd2;
    localparam logic [TYPE_BITS-1:0] REQ_RD_SPIN   = 2'd3;

    typedef struct packed {
        logic [TYPE_BITS-1:0]       req_type;
        logic [IDX_BITS-1:0]        row_index;
        logic [IDX_BITS-1:0]        col_index;
        logic signed [WIN_BITS-1:0] weight_value;
        logic                       spin_bit;
        logic [IDX_BITS-1:0]        start_site;
    } req_t;

    typedef struct packed {
        logic                spin_read;
        logic                converged;
        logic [IDX_BITS-1:0] flipped_site;
        logic                flipped;
    } result_t;

    // one accumulate slot issued alongside a memory read
    typedef struct packed {
        logic valid;
        logic first;
        logic own;
    } issue_t;

    // field evaluation of the site just scanned
    typedef struct packed {
        logic unstable;
        logic own;
    } status_t;

    // true when a request index addresses an existing site
    function automatic logic site_ok(input logic [IDX_BITS-1:0] idx);
        return (32'(idx) < N_SITES);
    endfunction

    function automatic logic [SITE_BITS-1:0] to_site(input logic [IDX_BITS-1:0] idx);
        return SITE_BITS'(idx);
    endfunction

    // row-major weight address
    function automatic logic [WADDR_BITS-1:0] weight_addr(
        input logic [SITE_BITS-1:0] row,
        input logic [SITE_BITS-1:0] col
    );
        return (WADDR_BITS'(row) * WADDR_BITS'(N_SITES)) + WADDR_BITS'(col);
    endfunction

    // wrap or sign extend the written coupling to the stored width
    function automatic logic [WEIGHT_BITS-1:0] fit_weight(
        input logic signed [WIN_BITS-1:0] w
    );
        return WEIGHT_BITS'(w);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hfar_ram.sv =====
// generic simple dual-port ram with one write port and a registered read port
// no dependencies
`default_nettype none

module hfar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hfar_field.sv =====
// local field accumulator: sums signed weight times spin over one weight row
// depends on hfar_pkg; fed by the weight and spin ram read ports
`default_nettype none

module hfar_field (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire hfar_pkg::issue_t                issue,
    input  wire logic [hfar_pkg::WEIGHT_BITS-1:0] weight_q,
    input  wire logic                            spin_q,
    output hfar_pkg::status_t                    status
);

    hfar_pkg::issue_t                         slot_reg;
    logic signed [hfar_pkg::ACC_BITS-1:0]     acc_reg;
    logic signed [hfar_pkg::ACC_BITS-1:0]     acc_next;
    logic                                     own_reg;
    logic                                     own_next;
    logic signed [hfar_pkg::ACC_BITS-1:0]     w_ext;
    logic signed [hfar_pkg::ACC_BITS-1:0]     term;

    // signed term for the weight now on the ram output
    always_comb begin
        w_ext = hfar_pkg::ACC_BITS'(signed'(weight_q));
        term  = spin_q ? w_ext : -w_ext;
        acc_next = acc_reg;
        own_next = own_reg;
        if (slot_reg.valid) begin
            acc_next = (slot_reg.first ? '0 : acc_reg) + term;
            if (slot_reg.own) begin
                own_next = spin_q;
            end
        end
    end

    // slot is registered to line up with the registered ram read
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        own_reg <= own_next;
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= issue;
        end
    end

    // a zero field is stable
    always_comb begin
        status.own      = own_reg;
        status.unstable = own_reg ? (acc_reg < 0) : (acc_reg > 0);
    end

endmodule

`default_nettype wire

// ===== rtl/core/hfar_seq.sv =====
// request sequencer: decodes requests, drives both rams, scans sites and
// holds the output register; depends on hfar_pkg
`default_nettype none

module hfar_seq (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire hfar_pkg::req_t                    req,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output hfar_pkg::result_t                      m_res,
    output logic                                   wram_we,
    output logic [hfar_pkg::WADDR_BITS-1:0]        wram_waddr,
    output logic [hfar_pkg::WEIGHT_BITS-1:0]       wram_wdata,
    output logic                                   wram_re,
    output logic [hfar_pkg::WADDR_BITS-1:0]        wram_raddr,
    output logic                                   sram_we,
    output logic [hfar_pkg::SITE_BITS-1:0]         sram_waddr,
    output logic                                   sram_wdata,
    output logic                                   sram_re,
    output logic [hfar_pkg::SITE_BITS-1:0]         sram_raddr,
    input  wire logic                              sram_rdata,
    output hfar_pkg::issue_t                       issue,
    input  wire hfar_pkg::status_t                 status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_RDSPIN,
        ST_RESP
    } state_t;

    localparam logic [hfar_pkg::SITE_BITS-1:0] LAST_SITE =
        hfar_pkg::SITE_BITS'(hfar_pkg::N_SITES - 1);

    state_t                          state_reg, state_next;
    logic [hfar_pkg::SITE_BITS-1:0]  site_reg, site_next;
    logic [hfar_pkg::SITE_BITS-1:0]  col_reg, col_next;
    logic [hfar_pkg::SITE_BITS-1:0]  count_reg, count_next;
    logic                            rd_ok_reg, rd_ok_next;
    hfar_pkg::result_t               pend_reg, pend_next;
    hfar_pkg::result_t               m_res_reg, m_res_next;
    logic                            m_valid_reg, m_valid_next;
    logic [hfar_pkg::SITE_BITS-1:0]  first_site;

    assign first_site = hfar_pkg::site_ok(req.start_site) ?
                        hfar_pkg::to_site(req.start_site) : '0;

    always_comb begin
        state_next   = state_reg;
        site_next    = site_reg;
        col_next     = col_reg;
        count_next   = count_reg;
        rd_ok_next   = rd_ok_reg;
        pend_next    = pend_reg;
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;

        s_ready    = (state_reg == ST_IDLE);
        wram_we    = 1'b0;
        wram_waddr = hfar_pkg::weight_addr(hfar_pkg::to_site(req.row_index),
                                           hfar_pkg::to_site(req.col_index));
        wram_wdata = hfar_pkg::fit_weight(req.weight_value);
        wram_re    = 1'b0;
        wram_raddr = hfar_pkg::weight_addr(site_reg, col_reg);
        sram_we    = 1'b0;
        sram_waddr = hfar_pkg::to_site(req.row_index);
        sram_wdata = req.spin_bit;
        sram_re    = 1'b0;
        sram_raddr = col_reg;
        issue      = '0;

        // output transaction taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pend_next = '0;
                    case (req.req_type)
                        hfar_pkg::REQ_WR_WEIGHT: begin
                            wram_we    = hfar_pkg::site_ok(req.row_index) &&
                                         hfar_pkg::site_ok(req.col_index);
                            state_next = ST_RESP;
                        end
                        hfar_pkg::REQ_WR_SPIN: begin
                            sram_we    = hfar_pkg::site_ok(req.row_index);
                            state_next = ST_RESP;
                        end
                        hfar_pkg::REQ_STEP: begin
                            site_next  = first_site;
                            col_next   = '0;
                            count_next = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            sram_re    = 1'b1;
                            sram_raddr = hfar_pkg::to_site(req.row_index);
                            rd_ok_next = hfar_pkg::site_ok(req.row_index);
                            state_next = ST_RDSPIN;
                        end
                    endcase
                end
            end
            // read one weight and one spin per cycle along the row
            ST_SCAN: begin
                wram_re     = 1'b1;
                sram_re     = 1'b1;
                issue.valid = 1'b1;
                issue.first = (col_reg == '0);
                issue.own   = (col_reg == site_reg);
                if (col_reg == LAST_SITE) begin
                    col_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EVAL;
            end
            // flip the first unstable site, report convergence once every site is stable, or move on to the next
            ST_EVAL: begin
                if (status.unstable) begin
                    sram_we                = 1'b1;
                    sram_waddr             = site_reg;
                    sram_wdata             = ~status.own;
                    pend_next.flipped      = 1'b1;
                    pend_next.flipped_site = hfar_pkg::IDX_BITS'(site_reg);
                    state_next             = ST_RESP;
                end else if (count_reg == LAST_SITE) begin
                    pend_next.converged = 1'b1;
                    state_next          = ST_RESP;
                end else begin
                    count_next = count_reg + 1'b1;
                    site_next  = (site_reg == LAST_SITE) ? '0 : site_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_RDSPIN: begin
                pend_next.spin_read = rd_ok_reg & sram_rdata;
                state_next          = ST_RESP;
            end
            // hand the result to the output register once it is free
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        site_reg  <= site_next;
        col_reg   <= col_next;
        count_reg <= count_next;
        rd_ok_reg <= rd_ok_next;
        pend_reg  <= pend_next;
        m_res_reg <= m_res_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hopfield_async_recall.sv =====
// top level of the hopfield recall engine: stream ports, weight and spin rams
// depends on hfar_pkg, hfar_ram, hfar_field and hfar_seq
//
// One request per transaction, one result per request. Writes go straight
// to the result stage; a spin read first waits for the spin ram output. An
// update step scans sites from start_site, wrapping at the last site; each
// examined site reads its whole weight row, since the weight ram delivers one
// coupling per cycle and the field is accumulated term by term, and the step
// ends at the first unstable site or once every site has been examined. A new
// request is accepted when the previous one has its result in the output
// register, even if that result has not yet been taken. Neither ram is
// cleared at reset: weights and spins must be written before a step or read
// uses them.
`default_nettype none

module hopfield_async_recall (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row_index, col_index, weight_value, spin_bit, start_site
    input  wire logic [39:0] s_tdata,
    // req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // flipped, flipped_site, converged, spin_read
    output logic [15:0]      m_tdata
);

    hfar_pkg::req_t                        req;
    hfar_pkg::result_t                     res;
    hfar_pkg::issue_t                      issue;
    hfar_pkg::status_t                     status;
    logic                                  wram_we;
    logic [hfar_pkg::WADDR_BITS-1:0]       wram_waddr;
    logic [hfar_pkg::WEIGHT_BITS-1:0]      wram_wdata;
    logic                                  wram_re;
    logic [hfar_pkg::WADDR_BITS-1:0]       wram_raddr;
    logic [hfar_pkg::WEIGHT_BITS-1:0]      wram_rdata;
    logic                                  sram_we;
    logic [hfar_pkg::SITE_BITS-1:0]        sram_waddr;
    logic                                  sram_wdata;
    logic                                  sram_re;
    logic [hfar_pkg::SITE_BITS-1:0]        sram_raddr;
    logic                                  sram_rdata;

    // unpack the request transaction
    always_comb begin
        req.req_type     = s_tuser;
        req.row_index    = s_tdata[5:0];
        req.col_index    = s_tdata[11:6];
        req.weight_value = signed'(s_tdata[27:12]);
        req.spin_bit     = s_tdata[28];
        req.start_site   = s_tdata[34:29];
    end

    // pack the result transaction
    assign m_tdata = {7'b0, res.spin_read, res.converged, res.flipped_site, res.flipped};

    hfar_ram #(
        .WIDTH (hfar_pkg::WEIGHT_BITS),
        .DEPTH (hfar_pkg::WDEPTH)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (wram_wdata),
        .re    (wram_re),
        .raddr (wram_raddr),
        .rdata (wram_rdata)
    );

    hfar_ram #(
        .WIDTH (1),
        .DEPTH (hfar_pkg::N_SITES)
    ) u_spin_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .re    (sram_re),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    hfar_field u_field (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .weight_q (wram_rdata),
        .spin_q   (sram_rdata),
        .status   (status)
    );

    hfar_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .req        (req),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (res),
        .wram_we    (wram_we),
        .wram_waddr (wram_waddr),
        .wram_wdata (wram_wdata),
        .wram_re    (wram_re),
        .wram_raddr (wram_raddr),
        .sram_we    (sram_we),
        .sram_waddr (sram_waddr),
        .sram_wdata (sram_wdata),
        .sram_re    (sram_re),
        .sram_raddr (sram_raddr),
        .sram_rdata (sram_rdata),
        .issue      (issue),
        .status     (status)
    );

endmodule

`default_nettype wire
